// ----- hw/rtl/rssp_pkg.sv -----
// ----------------------------------------------------------------------------
// rssp_pkg
// Shared constants, types and codes of the route split shortest path unit.
// ----------------------------------------------------------------------------
package rssp_pkg;

    localparam int MAX_CLIENTS = 64;
    localparam int COST_WIDTH  = 48;

    localparam int CLI_AW  = $clog2(MAX_CLIENTS);       // client store address
    localparam int CNT_W   = $clog2(MAX_CLIENTS + 1);   // counts 0..MAX_CLIENTS
    localparam int SPT_AW  = $clog2(MAX_CLIENTS + 1);   // split point address

    localparam int DIST_W  = 16 + CLI_AW;               // summed route distance
    localparam int LOAD_W  = 16 + CLI_AW;               // summed route load
    localparam int DUR_W   = 20;                        // signed service start
    localparam int ALT_W   = 26;                        // signed route time limit
    localparam int WARP_W  = 19 + CLI_AW;               // summed time warp
    localparam int LC_W    = 16 + LOAD_W;               // load penalty product
    localparam int WC_W    = 16 + WARP_W;               // warp penalty product
    localparam int RC_W    = WC_W + 2;                  // route cost
    localparam int SUM_W   = ((COST_WIDTH > RC_W) ? COST_WIDTH : RC_W) + 1;

    localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

    // configuration
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_PEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARP_PEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLACK_TOL = 3'd4;

    typedef struct packed {
        logic [15:0] demand;
        logic [15:0] service;
        logic [15:0] open;
        logic [15:0] close;
        logic [15:0] depot;
        logic [15:0] next_dist;
    } t_client;

    typedef struct packed {
        logic              cli_we;
        logic [CLI_AW-1:0] cli_waddr;
        logic              rd;
        logic [CLI_AW-1:0] cli_raddr;
        logic [SPT_AW-1:0] bca_addr;
        logic [SPT_AW-1:0] bcb_addr;
        logic              bc_init;
        logic              first;
        logic              e1;
        logic              e2;
        logic              e3;
        logic              e4;
        logic              e5;
        logic              e6;
        logic [SPT_AW-1:0] wr_j;
        logic [CLI_AW-1:0] wr_i;
        logic              tot_latch;
        logic              pred_rd;
        logic [SPT_AW-1:0] pred_raddr;
        logic              stk_we;
        logic [CLI_AW-1:0] stk_waddr;
        logic              stk_rd;
        logic [CLI_AW-1:0] stk_raddr;
        logic              out_load;
        logic              out_ns;
        logic              out_last;
        logic [CNT_W-1:0]  out_count;
    } t_cmd;

    typedef struct packed {
        logic              total_sat;
        logic [CLI_AW-1:0] pred;
    } t_sts;

endpackage

// ----- hw/rtl/rssp_if.sv -----
// ----------------------------------------------------------------------------
// rssp_if
// Client, result and configuration channels of the route split unit.
// ----------------------------------------------------------------------------
interface rssp_client_if;
    logic        valid;
    logic        ready;
    logic [15:0] demand;
    logic [15:0] svc_time;
    logic [15:0] window_open;
    logic [15:0] window_close;
    logic [15:0] depot_distance;
    logic [15:0] next_distance;
    logic        last_client;

    modport source (output valid, demand, svc_time, window_open, window_close,
                    depot_distance, next_distance, last_client, input ready);
    modport sink   (input valid, demand, svc_time, window_open, window_close,
                    depot_distance, next_distance, last_client, output ready);
endinterface

interface rssp_result_if;
    logic        valid;
    logic        ready;
    logic [6:0]  route_start;
    logic [47:0] total_cost;
    logic [6:0]  route_count;
    logic        no_solution;
    logic        last_route;

    modport source (output valid, route_start, total_cost, route_count, no_solution,
                    last_route, input ready);
    modport sink   (input valid, route_start, total_cost, route_count, no_solution,
                    last_route, output ready);
endinterface

interface rssp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rssp_dp.sv -----
// ----------------------------------------------------------------------------
// rssp_dp
// Datapath: client store, split cost and predecessor stores, route cost unit,
// route start stack, configuration registers and result register.
// ----------------------------------------------------------------------------
module rssp_dp import rssp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  t_client              i_client,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [6:0]           o_route_start,
    output logic [47:0]          o_total_cost,
    output logic [6:0]           o_route_count,
    output logic                 o_no_solution,
    output logic                 o_last_route
);

    logic [23:0] r_cap, r_mrt;
    logic [15:0] r_lpen, r_wpen, r_slack;

    t_client                 r_cli_mem [MAX_CLIENTS];
    logic [COST_WIDTH-1:0]   r_bc_mem  [MAX_CLIENTS+1];
    logic [MAX_CLIENTS:0]    r_bc_vld;
    logic [CLI_AW-1:0]       r_pred_mem [MAX_CLIENTS+1];
    logic [6:0]              r_stk_mem [MAX_CLIENTS];

    t_client                 r_cli;
    logic [COST_WIDTH-1:0]   r_bca, r_bcb, r_total;
    logic [CLI_AW-1:0]       r_pred_q;
    logic [6:0]              r_stk_q;

    logic [15:0]             r_psvc, r_pnext;
    logic [DIST_W-1:0]       r_dist;
    logic [LOAD_W-1:0]       r_load, r_lex;
    logic signed [DUR_W-1:0] r_dur, r_dur_pre, r_latest;
    logic [WARP_W-1:0]       r_warp;
    logic                    r_over;
    logic [DIST_W:0]         r_base;
    logic [LC_W-1:0]         r_lcost;
    logic [WC_W-1:0]         r_wcost;
    logic [RC_W-1:0]         r_rcost;
    logic [COST_WIDTH-1:0]   r_cost;

    logic [6:0]              r_o_start, r_o_count;
    logic [47:0]             r_o_total;
    logic                    r_o_ns, r_o_last;

    logic signed [DUR_W-1:0] n_dur_pre, n_latest, s_open, s_chain;
    logic signed [ALT_W-1:0] s_alt, s_close;
    logic signed [DUR_W:0]   s_excess, s_thr;
    logic [SUM_W-1:0]        s_sum;
    logic                    s_bc_we;
    logic [SPT_AW-1:0]       s_bc_waddr;
    logic [COST_WIDTH-1:0]   s_bc_wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 24'd65535;
            r_mrt   <= 24'd65535;
            r_lpen  <= 16'd256;
            r_wpen  <= 16'd256;
            r_slack <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY:  r_cap   <= i_cfg_data;
                CFG_MAX_TIME:  r_mrt   <= i_cfg_data;
                CFG_LOAD_PEN:  r_lpen  <= i_cfg_data[15:0];
                CFG_WARP_PEN:  r_wpen  <= i_cfg_data[15:0];
                CFG_SLACK_TOL: r_slack <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // client store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cli_we) begin
            r_cli_mem[i_cmd.cli_waddr] <= i_client;
        end
        if (i_cmd.rd) begin
            r_cli <= r_cli_mem[i_cmd.cli_raddr];
        end
    end

    // split cost store, unwritten points read as saturated
    assign s_bc_we    = i_cmd.bc_init || (i_cmd.e6 && (r_cost < r_bcb));
    assign s_bc_waddr = i_cmd.bc_init ? '0 : i_cmd.wr_j;
    assign s_bc_wdata = i_cmd.bc_init ? '0 : r_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_vld <= '0;
        end else if (i_cmd.bc_init) begin
            r_bc_vld <= {{MAX_CLIENTS{1'b0}}, 1'b1};
        end else if (s_bc_we) begin
            r_bc_vld[s_bc_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_bc_we) begin
            r_bc_mem[s_bc_waddr] <= s_bc_wdata;
        end
        if (i_cmd.rd) begin
            r_bca <= r_bc_vld[i_cmd.bca_addr] ? r_bc_mem[i_cmd.bca_addr] : COST_MAX;
            r_bcb <= r_bc_vld[i_cmd.bcb_addr] ? r_bc_mem[i_cmd.bcb_addr] : COST_MAX;
        end
        if (i_cmd.tot_latch) begin
            r_total <= r_bcb;
        end
    end

    // predecessor store and route start stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.e6 && (r_cost < r_bcb)) begin
            r_pred_mem[i_cmd.wr_j] <= i_cmd.wr_i;
        end
        if (i_cmd.pred_rd) begin
            r_pred_q <= r_pred_mem[i_cmd.pred_raddr];
        end
        if (i_cmd.stk_we) begin
            r_stk_mem[i_cmd.stk_waddr] <= {1'b0, r_pred_q} + 7'd1;
        end
        if (i_cmd.stk_rd) begin
            r_stk_q <= r_stk_mem[i_cmd.stk_raddr];
        end
    end

    assign o_sts.total_sat = (r_bcb == COST_MAX);
    assign o_sts.pred      = r_pred_q;

    // route cost evaluation, first stage: distance, load, start time, latest start
    always_comb begin
        s_open  = $signed({{(DUR_W-16){1'b0}}, r_cli.open});
        s_chain = r_dur + $signed({{(DUR_W-16){1'b0}}, r_psvc})
                        + $signed({{(DUR_W-16){1'b0}}, r_pnext});
        if (i_cmd.first) begin
            n_dur_pre = (r_cli.open > r_cli.depot) ? s_open
                        : $signed({{(DUR_W-16){1'b0}}, r_cli.depot});
        end else begin
            n_dur_pre = (s_open > s_chain) ? s_open : s_chain;
        end
        s_alt   = $signed({2'b00, r_mrt}) - $signed({{(ALT_W-16){1'b0}}, r_cli.service})
                                          - $signed({{(ALT_W-16){1'b0}}, r_cli.depot});
        s_close = $signed({{(ALT_W-16){1'b0}}, r_cli.close});
        n_latest = (s_alt < s_close) ? DUR_W'(s_alt) : DUR_W'(s_close);
    end

    // excess over the latest start
    assign s_excess = $signed({r_dur_pre[DUR_W-1], r_dur_pre})
                    - $signed({r_latest[DUR_W-1], r_latest});
    assign s_thr    = $signed({r_latest[DUR_W-1], r_latest})
                    + $signed({{(DUR_W-15){1'b0}}, r_slack});

    assign s_sum = SUM_W'(r_bca) + SUM_W'(r_rcost);

    always_ff @(posedge i_clk) begin
        if (i_cmd.e1) begin
            if (i_cmd.first) begin
                r_dist <= DIST_W'(r_cli.depot);
                r_load <= LOAD_W'(r_cli.demand);
                r_warp <= '0;
            end else begin
                r_dist <= r_dist + DIST_W'(r_pnext);
                r_load <= r_load + LOAD_W'(r_cli.demand);
            end
            r_dur_pre <= n_dur_pre;
            r_latest  <= n_latest;
            r_psvc    <= r_cli.service;
            r_pnext   <= r_cli.next_dist;
        end
        if (i_cmd.e2) begin
            if (r_dur_pre > r_latest) begin
                if ($signed({r_dur_pre[DUR_W-1], r_dur_pre}) > s_thr) begin
                    r_warp <= r_warp + WARP_W'(s_excess);
                end
                r_dur <= r_latest;
            end else begin
                r_dur <= r_dur_pre;
            end
            r_over <= ({3'b000, r_load} > ({1'b0, r_cap} + 25'(r_slack)));
            r_lex  <= LOAD_W'({2'b00, r_load} - r_cap);
            r_base <= {1'b0, r_dist} + (DIST_W+1)'(r_cli.depot);
        end
        if (i_cmd.e3) begin
            r_lcost <= r_over ? (LC_W'(r_lpen) * LC_W'(r_lex)) : '0;
            r_wcost <= WC_W'(r_wpen) * WC_W'(r_warp);
        end
        if (i_cmd.e4) begin
            r_rcost <= (RC_W'(r_base) << 8) + RC_W'(r_lcost) + RC_W'(r_wcost);
        end
        if (i_cmd.e5) begin
            r_cost <= (s_sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_WIDTH'(s_sum);
        end
    end

    // result register, total held with the route so a later split cannot disturb it
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_start <= i_cmd.out_ns ? 7'd1 : r_stk_q;
            r_o_total <= 48'(r_total);
            r_o_count <= i_cmd.out_ns ? 7'd0 : 7'(i_cmd.out_count);
            r_o_ns    <= i_cmd.out_ns;
            r_o_last  <= i_cmd.out_last;
        end
    end

    assign o_route_start = r_o_start;
    assign o_total_cost  = r_o_total;
    assign o_route_count = r_o_count;
    assign o_no_solution = r_o_ns;
    assign o_last_route  = r_o_last;

endmodule

// ----- hw/rtl/rssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rssp_ctrl
// Controller: client loading, split loop sequencing, backtrack and result
// hand-off.
// ----------------------------------------------------------------------------
module rssp_ctrl import rssp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_OUTER = 5'd1;
    localparam logic [4:0] ST_RD    = 5'd2;
    localparam logic [4:0] ST_E1    = 5'd3;
    localparam logic [4:0] ST_E2    = 5'd4;
    localparam logic [4:0] ST_E3    = 5'd5;
    localparam logic [4:0] ST_E4    = 5'd6;
    localparam logic [4:0] ST_E5    = 5'd7;
    localparam logic [4:0] ST_E6    = 5'd8;
    localparam logic [4:0] ST_TOT   = 5'd9;
    localparam logic [4:0] ST_TOT2  = 5'd10;
    localparam logic [4:0] ST_BT    = 5'd11;
    localparam logic [4:0] ST_BT2   = 5'd12;
    localparam logic [4:0] ST_PRD   = 5'd13;
    localparam logic [4:0] ST_PUT   = 5'd14;
    localparam logic [4:0] ST_NS    = 5'd15;

    logic [4:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CLI_AW-1:0] r_i, n_i;
    logic [SPT_AW-1:0] r_j, n_j;
    logic              r_first, n_first;
    logic [SPT_AW-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CLI_AW-1:0] r_ptr, n_ptr;
    logic              r_out_vld, n_out_vld;

    logic s_accept, s_room, s_out_free;

    assign s_accept   = i_in_valid && (r_state == ST_LOAD);
    assign s_room     = (r_count < CNT_W'(MAX_CLIENTS));
    assign s_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_first   = r_first;
        n_cur     = r_cur;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_out_vld = (r_out_vld && !i_out_ready);
        o_cmd     = '0;
        o_cmd.cli_waddr  = r_count[CLI_AW-1:0];
        o_cmd.cli_raddr  = CLI_AW'(r_j - SPT_AW'(1));
        o_cmd.bca_addr   = SPT_AW'(r_i);
        o_cmd.bcb_addr   = r_j;
        o_cmd.first      = r_first;
        o_cmd.wr_j       = r_j;
        o_cmd.wr_i       = r_i;
        o_cmd.pred_raddr = r_cur;
        o_cmd.stk_waddr  = r_cnt[CLI_AW-1:0];
        o_cmd.stk_raddr  = r_ptr;
        o_cmd.out_count  = r_cnt;
        o_cmd.out_last   = (r_ptr == '0);

        case (r_state)
            ST_LOAD: begin
                if (s_accept) begin
                    o_cmd.cli_we = s_room;
                    n_count = s_room ? r_count + CNT_W'(1) : r_count;
                    if (i_in_last) begin
                        n_n          = n_count;
                        n_count      = '0;
                        n_i          = '0;
                        o_cmd.bc_init = 1'b1;
                        n_state      = ST_OUTER;
                    end
                end
            end
            ST_OUTER: begin
                n_j     = SPT_AW'(r_i) + SPT_AW'(1);
                n_first = 1'b1;
                n_state = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_E1;
            end
            ST_E1: begin
                o_cmd.e1 = 1'b1;
                n_state  = ST_E2;
            end
            ST_E2: begin
                o_cmd.e2 = 1'b1;
                n_state  = ST_E3;
            end
            ST_E3: begin
                o_cmd.e3 = 1'b1;
                n_state  = ST_E4;
            end
            ST_E4: begin
                o_cmd.e4 = 1'b1;
                n_state  = ST_E5;
            end
            ST_E5: begin
                o_cmd.e5 = 1'b1;
                n_state  = ST_E6;
            end
            ST_E6: begin
                o_cmd.e6 = 1'b1;
                if (SPT_AW'(r_n) == r_j) begin
                    if (CNT_W'(r_i) == r_n - CNT_W'(1)) begin
                        n_state = ST_TOT;
                    end else begin
                        n_i     = r_i + CLI_AW'(1);
                        n_state = ST_OUTER;
                    end
                end else begin
                    n_j     = r_j + SPT_AW'(1);
                    n_first = 1'b0;
                    n_state = ST_RD;
                end
            end
            ST_TOT: begin
                o_cmd.rd       = 1'b1;
                o_cmd.bcb_addr = SPT_AW'(r_n);
                n_state        = ST_TOT2;
            end
            ST_TOT2: begin
                o_cmd.tot_latch = 1'b1;
                n_cur = SPT_AW'(r_n);
                n_cnt = '0;
                n_state = i_sts.total_sat ? ST_NS : ST_BT;
            end
            ST_BT: begin
                o_cmd.pred_rd = 1'b1;
                n_state       = ST_BT2;
            end
            ST_BT2: begin
                // push this route's first client, walk back to its split point
                o_cmd.stk_we = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                n_cur = SPT_AW'(i_sts.pred);
                if (i_sts.pred == '0) begin
                    n_ptr   = r_cnt[CLI_AW-1:0];
                    n_state = ST_PRD;
                end else begin
                    n_state = ST_BT;
                end
            end
            ST_PRD: begin
                o_cmd.stk_rd = 1'b1;
                n_state      = ST_PUT;
            end
            ST_PUT: begin
                if (s_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld = 1'b1;
                    if (r_ptr == '0) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_ptr   = r_ptr - CLI_AW'(1);
                        n_state = ST_PRD;
                    end
                end
            end
            ST_NS: begin
                o_cmd.out_ns   = 1'b1;
                o_cmd.out_last = 1'b1;
                if (s_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_i     <= n_i;
        r_j     <= n_j;
        r_first <= n_first;
        r_cur   <= n_cur;
        r_cnt   <= n_cnt;
        r_ptr   <= n_ptr;
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = r_out_vld;

endmodule

// ----- hw/rtl/route_split_shortest_path_unit.sv -----
// ----------------------------------------------------------------------------
// route_split_shortest_path_unit
// Splits a giant tour of clients into depot routes at minimum penalized cost.
// ----------------------------------------------------------------------------
// Clients are taken one per cycle in tour order while the unit is loading;
// the one marked last starts the split. The split walks all n(n+1)/2
// candidate routes through a single shared route-cost datapath, each
// candidate taking one registered store read, then six evaluation steps
// ending in the compare and update, with a setup step before the candidates
// of each start point. The route list is then traced back through the
// predecessor store onto the route start stack and handed out from that
// stack, waiting while the output is not ready. Split points are tracked by
// valid bits, so no clearing pass is needed after reset. Results are one per
// route in tour order, or one no-solution result when the cost saturates.
// Configuration writes are always taken and belong in idle periods.
module route_split_shortest_path_unit import rssp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rssp_client_if.sink          i_client,
    rssp_result_if.source        o_result,
    rssp_cfg_if.sink             i_cfg
);

    t_cmd    s_cmd;
    t_sts    s_sts;
    t_client s_client;

    assign s_client.demand    = i_client.demand;
    assign s_client.service   = i_client.svc_time;
    assign s_client.open      = i_client.window_open;
    assign s_client.close     = i_client.window_close;
    assign s_client.depot     = i_client.depot_distance;
    assign s_client.next_dist = i_client.next_distance;

    assign i_cfg.ready = 1'b1;

    rssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_client.valid),
        .i_in_last   (i_client.last_client),
        .o_in_ready  (i_client.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    rssp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_client      (s_client),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_route_start (o_result.route_start),
        .o_total_cost  (o_result.total_cost),
        .o_route_count (o_result.route_count),
        .o_no_solution (o_result.no_solution),
        .o_last_route  (o_result.last_route)
    );

endmodule
